// ===== hw/rtl/slfr_pkg.sv =====
// Shared types, codes and constants of the sync/length frame receiver.
package slfr_pkg;

  localparam int MAX_WINDOW_BYTES_DEF = 256;

  localparam logic [7:0] SYNC_FIRST   = 8'hAA;
  localparam logic [7:0] SYNC_SECOND  = 8'h55;
  localparam logic [7:0] HEADER_LAST  = 8'd4;
  localparam logic [15:0] SYNC_SUM    = 16'h00FF;

  typedef enum logic [1:0] {
    FUNC_BYTE  = 2'd0,
    FUNC_OPEN  = 2'd1,
    FUNC_CLOSE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD    = 3'd0,
    KIND_ACCEPT     = 3'd1,
    KIND_BADSUM     = 3'd2,
    KIND_UNEXPECTED = 3'd3,
    KIND_FAILED     = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REG_MASTER_ADDR = 3'd0,
    REG_EXP_SOURCE  = 3'd1,
    REG_EXP_CONTROL = 3'd2,
    REG_EXP_FUNC    = 3'd3,
    REG_CNT_RELOAD  = 3'd4
  } reg_idx_t;

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_SYNC2   = 7'b0000010,
    PH_HEADER  = 7'b0000100,
    PH_PAYLOAD = 7'b0001000,
    PH_SUM_HI  = 7'b0010000,
    PH_SUM_LO  = 7'b0100000,
    PH_IDLE    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] own_address;
    logic [7:0] expected_source;
    logic [7:0] expected_control;
    logic [7:0] expected_function;
    logic [7:0] offline_countdown_reload;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] index;
    logic       online;
  } result_t;

endpackage

// ===== hw/rtl/slfr_if.sv =====
// Valid/ready channel interfaces for receiver input items and results.
interface slfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface slfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_kind;
  logic [7:0] out_byte;
  logic [7:0] byte_index;
  logic       online;

  modport source (output valid, output out_kind, output out_byte, output byte_index,
                  output online, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input byte_index,
                  input online, output ready);
endinterface

// ===== hw/rtl/slfr_core.sv =====
// Frame parser state and per-item next-state and result logic.
module slfr_core #(
  parameter int MaxWindowBytes = slfr_pkg::MAX_WINDOW_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [1:0]        func,
  input  logic [7:0]        rx_byte,
  input  slfr_pkg::cfg_t    cfg,
  output slfr_pkg::result_t res
);
  import slfr_pkg::*;

  localparam int CntW = $clog2(MaxWindowBytes + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxWindowBytes);

  phase_t          rx_phase, rx_phase_next;
  logic [7:0]      frame_position, frame_position_next;
  logic [7:0]      payload_length, payload_length_next;
  logic [15:0]     running_sum, running_sum_next;
  logic            header_matches, header_matches_next;
  logic [7:0]      received_sum_high, received_sum_high_next;
  logic            window_accepted, window_accepted_next;
  logic [CntW-1:0] window_byte_count, window_byte_count_next;
  logic            partner_online, partner_online_next;
  logic [7:0]      offline_countdown, offline_countdown_next;

  logic [15:0] sum_add;
  logic [7:0]  pos_inc;
  logic        hdr_ok;

  always_comb begin
    sum_add = running_sum + {8'd0, rx_byte};
    pos_inc = frame_position + 8'd1;
    case (frame_position)
      8'd0:    hdr_ok = (rx_byte == cfg.expected_source);
      8'd1:    hdr_ok = (rx_byte == cfg.own_address);
      8'd2:    hdr_ok = (rx_byte == cfg.expected_control);
      8'd3:    hdr_ok = (rx_byte == cfg.expected_function);
      default: hdr_ok = 1'b1;
    endcase
  end

  always_comb begin
    rx_phase_next          = rx_phase;
    frame_position_next    = frame_position;
    payload_length_next    = payload_length;
    running_sum_next       = running_sum;
    header_matches_next    = header_matches;
    received_sum_high_next = received_sum_high;
    window_accepted_next   = window_accepted;
    window_byte_count_next = window_byte_count;
    partner_online_next    = partner_online;
    offline_countdown_next = offline_countdown;
    res = '{valid: 1'b0, kind: KIND_PAYLOAD, data: 8'd0, index: 8'd0,
            online: partner_online};

    unique case (func_t'(func))
      FUNC_BYTE: begin
        if (window_byte_count < CntMax) begin
          window_byte_count_next = window_byte_count + CntW'(1);
          unique case (rx_phase)
            PH_HUNT: begin
              if (rx_byte == SYNC_FIRST) rx_phase_next = PH_SYNC2;
            end
            PH_SYNC2: begin
              if (rx_byte == SYNC_SECOND) begin
                rx_phase_next       = PH_HEADER;
                frame_position_next = 8'd0;
                running_sum_next    = SYNC_SUM;
                header_matches_next = 1'b1;
              end else if (rx_byte != SYNC_FIRST) begin
                rx_phase_next = PH_HUNT;
              end
            end
            PH_HEADER: begin
              running_sum_next    = sum_add;
              header_matches_next = header_matches && hdr_ok;
              if (frame_position >= HEADER_LAST) begin
                payload_length_next = rx_byte;
                frame_position_next = 8'd0;
                rx_phase_next       = (rx_byte == 8'd0) ? PH_SUM_HI : PH_PAYLOAD;
              end else begin
                frame_position_next = pos_inc;
              end
            end
            PH_PAYLOAD: begin
              running_sum_next    = sum_add;
              frame_position_next = pos_inc;
              if (pos_inc >= payload_length) rx_phase_next = PH_SUM_HI;
              if (header_matches) begin
                res.valid = 1'b1;
                res.kind  = KIND_PAYLOAD;
                res.data  = rx_byte;
                res.index = frame_position;
              end
            end
            PH_SUM_HI: begin
              received_sum_high_next = rx_byte;
              rx_phase_next          = PH_SUM_LO;
            end
            PH_SUM_LO: begin
              res.valid = 1'b1;
              if (received_sum_high != running_sum[15:8] || rx_byte != running_sum[7:0]) begin
                rx_phase_next = PH_HUNT;
                res.kind      = KIND_BADSUM;
              end else if (!header_matches) begin
                rx_phase_next = PH_HUNT;
                res.kind      = KIND_UNEXPECTED;
              end else begin
                window_accepted_next = 1'b1;
                rx_phase_next        = PH_IDLE;
                partner_online_next  = 1'b1;
                if (!partner_online) offline_countdown_next = cfg.offline_countdown_reload;
                res.kind   = KIND_ACCEPT;
                res.online = 1'b1;
              end
            end
            PH_IDLE: begin
            end
            default: begin
            end
          endcase
        end
      end
      FUNC_OPEN: begin
        rx_phase_next          = PH_HUNT;
        frame_position_next    = 8'd0;
        payload_length_next    = 8'd0;
        running_sum_next       = 16'd0;
        header_matches_next    = 1'b0;
        received_sum_high_next = 8'd0;
        window_accepted_next   = 1'b0;
        window_byte_count_next = '0;
      end
      FUNC_CLOSE: begin
        rx_phase_next = PH_IDLE;
        if (!window_accepted) begin
          if (partner_online) begin
            if (offline_countdown <= 8'd1) begin
              offline_countdown_next = 8'd0;
              partner_online_next    = 1'b0;
            end else begin
              offline_countdown_next = offline_countdown - 8'd1;
            end
          end
          res.valid  = 1'b1;
          res.kind   = KIND_FAILED;
          res.online = partner_online_next;
        end
      end
      FUNC_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase          <= PH_HUNT;
      frame_position    <= 8'd0;
      payload_length    <= 8'd0;
      running_sum       <= 16'd0;
      header_matches    <= 1'b0;
      received_sum_high <= 8'd0;
      window_accepted   <= 1'b0;
      window_byte_count <= '0;
      partner_online    <= 1'b0;
      offline_countdown <= 8'd0;
    end else if (step) begin
      rx_phase          <= rx_phase_next;
      frame_position    <= frame_position_next;
      payload_length    <= payload_length_next;
      running_sum       <= running_sum_next;
      header_matches    <= header_matches_next;
      received_sum_high <= received_sum_high_next;
      window_accepted   <= window_accepted_next;
      window_byte_count <= window_byte_count_next;
      partner_online    <= partner_online_next;
      offline_countdown <= offline_countdown_next;
    end
  end

endmodule

// ===== hw/rtl/sync_length_frame_receiver_unit.sv =====
// Top level of the sync/length frame receiver: registers, handshake, result register.
//
// Takes one transaction per clock: each byte, window open or window close is
// accepted in the cycle it is offered and its result, if any, appears in the
// result register on the next cycle. The only stall comes from the result
// channel: a new item is taken whenever the result register is empty or being
// taken in the same cycle. Frames are the 0xAA 0x55 sync pair, five header
// bytes (source, destination, control, function, length), the payload and a
// big-endian 16-bit byte sum over everything from the sync pair on. Only the
// first MaxWindowBytes bytes of a window are looked at. Registers are written
// through cfg_we/cfg_index/cfg_data and must change only while the block is idle.
module sync_length_frame_receiver_unit #(
  parameter int MaxWindowBytes = slfr_pkg::MAX_WINDOW_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  slfr_in_if.sink    rx,
  slfr_out_if.source res,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import slfr_pkg::*;

  cfg_t    cfg;
  result_t core_res;
  logic    step;

  assign rx.ready = !res.valid || res.ready;
  assign step     = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{own_address: 8'd0, expected_source: 8'd0, expected_control: 8'd0,
               expected_function: 8'd0, offline_countdown_reload: 8'd3};
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MASTER_ADDR: cfg.own_address              <= cfg_data;
        REG_EXP_SOURCE:  cfg.expected_source          <= cfg_data;
        REG_EXP_CONTROL: cfg.expected_control         <= cfg_data;
        REG_EXP_FUNC:    cfg.expected_function        <= cfg_data;
        REG_CNT_RELOAD:  cfg.offline_countdown_reload <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  slfr_core #(
    .MaxWindowBytes(MaxWindowBytes)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .func    (rx.func),
    .rx_byte (rx.rx_byte),
    .cfg     (cfg),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (rx.ready) begin
      res.valid <= step && core_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && core_res.valid) begin
      res.out_kind   <= core_res.kind;
      res.out_byte   <= core_res.data;
      res.byte_index <= core_res.index;
      res.online     <= core_res.online;
    end
  end

endmodule

// ===== hw/rtl/slfr_checker.sv =====
// Port-level assertions for the frame receiver, bound to the top level.
module slfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] out_kind,
  input logic [7:0] out_byte,
  input logic [7:0] byte_index,
  input logic       online
);
  import slfr_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_kind) && $stable(out_byte))
    else $error("result dropped or changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> rx_ready)
    else $error("input stalled with an empty result register");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_kind != KIND_PAYLOAD |-> out_byte == 8'd0 && byte_index == 8'd0)
    else $error("status result carries payload data");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_kind <= KIND_FAILED)
    else $error("undefined result kind");

  a_accept_online: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_kind == KIND_ACCEPT |-> online)
    else $error("accepted frame without online flag");

endmodule

bind sync_length_frame_receiver_unit slfr_checker u_slfr_checker (
  .clk        (clk),
  .rst        (rst),
  .rx_ready   (rx.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .out_kind   (res.out_kind),
  .out_byte   (res.out_byte),
  .byte_index (res.byte_index),
  .online     (res.online)
);

// ===== bench/sync_length_frame_receiver_unit_test.sv =====
// Self-checking testbench of the sync/length frame receiver: framed byte traffic, windows, status.
module sync_length_frame_receiver_unit_test;
  import slfr_pkg::*;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] data;
    logic [7:0] index;
    logic       online;
  } frame_result_t;

  class frame_tracker;
    frame_result_t expected[$];
    int failures;
    int results_seen;
    int kind_count[8];

    logic [7:0] own_addr;
    logic [7:0] want_src;
    logic [7:0] want_ctrl;
    logic [7:0] want_func;
    logic [7:0] reload;

    phase_t      rx_state;
    logic [7:0]  pos;
    logic [7:0]  plen;
    logic [15:0] sum;
    bit          hdr_ok;
    logic [7:0]  sum_hi;
    bit          accepted;
    int unsigned win_count;
    bit          online;
    logic [7:0]  countdown;

    function new();
      own_addr  = 8'h00;
      want_src  = 8'h00;
      want_ctrl = 8'h00;
      want_func = 8'h00;
      reload    = 8'd3;
      open_window();
      online    = 1'b0;
      countdown = 8'd0;
    endfunction

    function void open_window();
      rx_state  = PH_HUNT;
      pos       = 8'd0;
      plen      = 8'd0;
      sum       = 16'd0;
      hdr_ok    = 1'b0;
      sum_hi    = 8'd0;
      accepted  = 1'b0;
      win_count = 0;
    endfunction

    function void set_reg(reg_idx_t r, logic [7:0] v);
      case (r)
        REG_MASTER_ADDR: own_addr = v;
        REG_EXP_SOURCE:  want_src = v;
        REG_EXP_CONTROL: want_ctrl = v;
        REG_EXP_FUNC:    want_func = v;
        REG_CNT_RELOAD:  reload = v;
        default: ;
      endcase
    endfunction

    function void push(kind_t k, logic [7:0] d, logic [7:0] i);
      frame_result_t r;
      r.kind   = k;
      r.data   = d;
      r.index  = i;
      r.online = online;
      expected = {expected, r};
    endfunction

    function void take_byte(logic [7:0] b);
      logic [7:0] idx;
      if (win_count >= MAX_WINDOW_BYTES_DEF) return;
      win_count++;
      case (rx_state)
        PH_HUNT: begin
          if (b == SYNC_FIRST) rx_state = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (b == SYNC_SECOND) begin
            rx_state = PH_HEADER;
            pos      = 8'd0;
            sum      = SYNC_SUM;
            hdr_ok   = 1'b1;
          end else if (b != SYNC_FIRST) begin
            rx_state = PH_HUNT;
          end
        end
        PH_HEADER: begin
          sum = sum + b;
          if (pos == 8'd0 && b != want_src) hdr_ok = 1'b0;
          if (pos == 8'd1 && b != own_addr) hdr_ok = 1'b0;
          if (pos == 8'd2 && b != want_ctrl) hdr_ok = 1'b0;
          if (pos == 8'd3 && b != want_func) hdr_ok = 1'b0;
          if (pos >= HEADER_LAST) begin
            plen     = b;
            pos      = 8'd0;
            rx_state = (b == 8'd0) ? PH_SUM_HI : PH_PAYLOAD;
          end else begin
            pos++;
          end
        end
        PH_PAYLOAD: begin
          idx = pos;
          sum = sum + b;
          pos++;
          if (pos >= plen) rx_state = PH_SUM_HI;
          if (hdr_ok) push(KIND_PAYLOAD, b, idx);
        end
        PH_SUM_HI: begin
          sum_hi   = b;
          rx_state = PH_SUM_LO;
        end
        PH_SUM_LO: begin
          if (sum_hi != sum[15:8] || b != sum[7:0]) begin
            rx_state = PH_HUNT;
            push(KIND_BADSUM, 8'd0, 8'd0);
          end else if (!hdr_ok) begin
            rx_state = PH_HUNT;
            push(KIND_UNEXPECTED, 8'd0, 8'd0);
          end else begin
            accepted = 1'b1;
            rx_state = PH_IDLE;
            if (!online) begin
              online    = 1'b1;
              countdown = reload;
            end
            push(KIND_ACCEPT, 8'd0, 8'd0);
          end
        end
        default: ;
      endcase
    endfunction

    function void note_item(func_t f, logic [7:0] b);
      case (f)
        FUNC_BYTE: take_byte(b);
        FUNC_OPEN: open_window();
        FUNC_CLOSE: begin
          rx_state = PH_IDLE;
          if (!accepted) begin
            if (online) begin
              if (countdown <= 8'd1) begin
                countdown = 8'd0;
                online    = 1'b0;
              end else begin
                countdown--;
              end
            end
            push(KIND_FAILED, 8'd0, 8'd0);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [2:0] k, logic [7:0] d, logic [7:0] i, logic on);
      frame_result_t e;
      results_seen++;
      if (expected.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result with nothing pending: kind %0d byte %h index %0d online %b",
                   k, d, i, on);
        return;
      end
      e = expected.pop_front();
      kind_count[e.kind]++;
      if (e.kind !== k || e.data !== d || e.index !== i || e.online !== on) begin
        failures++;
        if (failures <= 10)
          $display({"mismatch: expected kind %0d byte %h index %0d online %b, ",
                    "got kind %0d byte %h index %0d online %b"},
                   e.kind, e.data, e.index, e.online, k, d, i, on);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  slfr_in_if  rx_ch ();
  slfr_out_if res_ch ();

  sync_length_frame_receiver_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_tracker tracker = new;

  cfg_t cur_cfg;
  bit   src_idle;
  bit   sink_idle;
  bit   long_hold_req;
  int   sent_items;
  int   settings_used;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("sync_length_frame_receiver_unit_test: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready)
        tracker.check_result(res_ch.out_kind, res_ch.out_byte, res_ch.byte_index,
                             res_ch.online);
      if (rx_ch.valid && rx_ch.ready)
        tracker.note_item(func_t'(rx_ch.func), rx_ch.rx_byte);
    end
  end

  initial begin
    int hold_left;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = 59;
        res_ch.ready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        hold_left     = $urandom_range(0, 2);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(func_t f, logic [7:0] b);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.func    <= f;
    rx_ch.rx_byte <= b;
    sent_items++;
    do @(posedge clk); while (!rx_ch.ready);
  endtask

  task automatic send_frame(cfg_t h, int len, bit bad_sum, int fill);
    logic [15:0] sum;
    logic [7:0]  hdr[5];
    logic [7:0]  b;
    hdr[0] = h.expected_source;
    hdr[1] = h.own_address;
    hdr[2] = h.expected_control;
    hdr[3] = h.expected_function;
    hdr[4] = 8'(len);
    sum    = SYNC_SUM;
    send_item(FUNC_BYTE, SYNC_FIRST);
    send_item(FUNC_BYTE, SYNC_SECOND);
    for (int i = 0; i < 5; i++) begin
      sum = sum + hdr[i];
      send_item(FUNC_BYTE, hdr[i]);
    end
    for (int i = 0; i < len; i++) begin
      b   = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      sum = sum + b;
      send_item(FUNC_BYTE, b);
    end
    if (bad_sum) sum = sum ^ (16'd1 << $urandom_range(0, 15));
    send_item(FUNC_BYTE, sum[15:8]);
    send_item(FUNC_BYTE, sum[7:0]);
  endtask

  task automatic write_reg(reg_idx_t r, logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    tracker.set_reg(r, v);
  endtask

  task automatic wait_quiet();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(cfg_t c);
    wait_quiet();
    write_reg(REG_MASTER_ADDR, c.own_address);
    write_reg(REG_EXP_SOURCE, c.expected_source);
    write_reg(REG_EXP_CONTROL, c.expected_control);
    write_reg(REG_EXP_FUNC, c.expected_function);
    write_reg(REG_CNT_RELOAD, c.offline_countdown_reload);
    cfg_we <= 1'b0;
    cur_cfg = c;
    settings_used++;
  endtask

  function automatic int pick_len();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 24);
    return $urandom_range(0, 6);
  endfunction

  function automatic cfg_t random_cfg(logic [7:0] reload_val);
    cfg_t c;
    c.own_address              = 8'($urandom_range(0, 255));
    c.expected_source          = 8'($urandom_range(0, 255));
    c.expected_control         = 8'($urandom_range(0, 255));
    c.expected_function        = 8'($urandom_range(0, 255));
    c.offline_countdown_reload = reload_val;
    return c;
  endfunction

  task automatic run_window(bit calm);
    int   nseg;
    int   choice;
    int   k;
    bit   doomed;
    cfg_t h;
    if (!calm) begin
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
    end
    if ($urandom_range(0, 15) != 0) send_item(FUNC_OPEN, 8'($urandom_range(0, 255)));
    doomed = ($urandom_range(0, 2) == 0);
    nseg   = $urandom_range(1, 3);
    for (int s = 0; s < nseg; s++) begin
      choice = $urandom_range(0, 99);
      h      = cur_cfg;
      if (choice < 10) begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++)
          send_item(FUNC_BYTE, ($urandom_range(0, 2) == 0) ? SYNC_FIRST
                                                            : 8'($urandom_range(0, 255)));
      end else if (choice < 50 && !doomed) begin
        send_frame(h, pick_len(), 1'b0, -1);
      end else if (choice < 62) begin
        send_frame(h, pick_len(), 1'b1, -1);
      end else if (choice < 75) begin
        case ($urandom_range(0, 3))
          0: h.expected_source   ^= 8'($urandom_range(1, 255));
          1: h.own_address       ^= 8'($urandom_range(1, 255));
          2: h.expected_control  ^= 8'($urandom_range(1, 255));
          default: h.expected_function ^= 8'($urandom_range(1, 255));
        endcase
        send_frame(h, pick_len(), 1'b0, -1);
      end else if (choice < 85) begin
        send_item(FUNC_BYTE, SYNC_FIRST);
        send_item(FUNC_BYTE, SYNC_SECOND);
        k = $urandom_range(0, 6);
        for (int i = 0; i < k; i++) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
        send_item(($urandom_range(0, 1) == 0) ? FUNC_OPEN : FUNC_CLOSE,
                  8'($urandom_range(0, 255)));
      end else if (choice < 87) begin
        send_frame(h, $urandom_range(230, 255), doomed, -1);
      end else if (choice < 92) begin
        k = $urandom_range(1, 2);
        for (int i = 0; i < k; i++) send_item(FUNC_NONE, 8'($urandom_range(0, 255)));
      end else begin
        h = random_cfg(cur_cfg.offline_countdown_reload);
        send_frame(h, pick_len(), 1'b0, -1);
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, 3);
      for (int i = 0; i < k; i++) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
    end
    send_item(FUNC_CLOSE, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 5) == 0) send_item(FUNC_CLOSE, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_random(int n, bit pressure, bit calm);
    int stop;
    stop = sent_items + n;
    if (pressure) begin
      long_hold_req = 1'b1;
      send_item(FUNC_OPEN, 8'h00);
      send_frame(cur_cfg, 24, 1'b0, -1);
      send_item(FUNC_CLOSE, 8'hFF);
    end
    while (sent_items < stop) run_window(calm);
  endtask

  task automatic run_directed();
    cfg_t h;
    h = cur_cfg;
    send_item(FUNC_CLOSE, 8'h00);
    send_item(FUNC_NONE, 8'hFF);
    send_item(FUNC_OPEN, 8'hAA);
    send_item(FUNC_BYTE, SYNC_FIRST);
    send_frame(h, 1, 1'b0, 8'hFF);
    send_item(FUNC_BYTE, SYNC_FIRST);
    send_item(FUNC_CLOSE, 8'h55);
    send_item(FUNC_CLOSE, 8'h00);
    send_item(FUNC_BYTE, 8'h12);
    send_item(FUNC_OPEN, 8'h00);
    send_frame(h, 0, 1'b1, 0);
    send_item(FUNC_CLOSE, 8'hFF);
  endtask

  initial begin
    cfg_t c;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_MASTER_ADDR;
    cfg_data      = 8'h00;
    rx_ch.valid   = 1'b0;
    rx_ch.func    = FUNC_BYTE;
    rx_ch.rx_byte = 8'h00;
    src_idle      = 1'b1;
    sink_idle     = 1'b1;
    long_hold_req = 1'b0;
    sent_items    = 0;
    settings_used = 1;
    cur_cfg       = '{default: 8'h00};
    cur_cfg.offline_countdown_reload = 8'd3;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    apply_settings(random_cfg(8'($urandom_range(1, 255))));
    run_random(380, 1'b1, 1'b0);

    c = '{default: 8'hFF};
    apply_settings(c);
    run_random(380, 1'b0, 1'b0);

    c = '{default: 8'h00};
    c.offline_countdown_reload = 8'd1;
    apply_settings(c);
    run_random(380, 1'b1, 1'b0);

    apply_settings(random_cfg(8'd0));
    run_random(380, 1'b0, 1'b0);

    src_idle  = 1'b0;
    sink_idle = 1'b0;
    apply_settings(random_cfg(8'd2));
    run_random(380, 1'b0, 1'b1);

    wait_quiet();
    repeat (8) @(posedge clk);
    if (tracker.expected.size() != 0) tracker.failures++;

    $display("covered %0d input transactions and %0d results under %0d register settings",
             sent_items, tracker.results_seen, settings_used);
    $display("accepted %0d, bad checksum %0d, unexpected %0d, failed windows %0d, payload %0d",
             tracker.kind_count[KIND_ACCEPT], tracker.kind_count[KIND_BADSUM],
             tracker.kind_count[KIND_UNEXPECTED], tracker.kind_count[KIND_FAILED],
             tracker.kind_count[KIND_PAYLOAD]);
    if (tracker.failures == 0) begin
      $display("sync_length_frame_receiver_unit_test: clean");
    end else begin
      $display("%0d mismatches", tracker.failures);
      $display("sync_length_frame_receiver_unit_test: errors");
    end
    $finish;
  end

endmodule
